// ===== design/quicksort_cutoff_insertion_sorter_assert.svh =====
// Assertion macros shared by the checker of the batch sorter.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef QUICKSORT_CUTOFF_INSERTION_SORTER_ASSERT_SVH
`define QUICKSORT_CUTOFF_INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QCIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define QCIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/qcis_pkg.sv =====
// Shared types and constants of the batch sorter.
// Depends on nothing; used by every module of the block.
package qcis_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int CUT_W     = 7;
  localparam logic [CUT_W-1:0] CUT_RST = 7'd8;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
  } out_item_t;

endpackage

// ===== design/qcis_core.sv =====
// Sort sequencer of the batch sorter: element store, range stack, one comparator.
// Depends on qcis_pkg.
module qcis_core #(
  parameter int DEPTH = qcis_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  qcis_pkg::in_item_t                  item,
  input  logic [qcis_pkg::CUT_W-1:0]          cutoff,
  output logic                                busy,
  output logic                                res_valid,
  output logic signed [qcis_pkg::DATA_W-1:0]  res_value,
  output logic                                res_last
);
  import qcis_pkg::*;

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > CUT_W) ? CW : CUT_W) + 2;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_POP   = 17'h00002,
    S_PENT  = 17'h00004,
    S_PPIV  = 17'h00008,
    S_PRD   = 17'h00010,
    S_PCMP  = 17'h00020,
    S_PSW1  = 17'h00040,
    S_PSW2  = 17'h00080,
    S_FS1   = 17'h00100,
    S_FS2   = 17'h00200,
    S_PUSHL = 17'h00400,
    S_PUSHR = 17'h00800,
    S_IRD   = 17'h01000,
    S_IKEY  = 17'h02000,
    S_IRDJ  = 17'h04000,
    S_ICMP  = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [2*IW-1:0]          stk [DEPTH];

  state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt, sp_r, sp_nxt, j_r, j_nxt, ip_r, ip_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [DATA_W-1:0] pivot_r, pivot_nxt, tmp_r, tmp_nxt, rdata_r;
  logic [2*IW-1:0] srd_r;
  logic ov_r, ov_nxt, ol_r, ol_nxt;

  logic m_re, m_we, s_re, s_we;
  logic [IW-1:0] m_raddr, m_waddr, s_raddr, s_waddr;
  logic signed [DATA_W-1:0] m_wdata;
  logic [2*IW-1:0] s_wdata;
  logic [CW-1:0] fill_add;
  logic signed [DATA_W-1:0] cmp_a, cmp_b;
  logic cmp_lt;

  // The single comparator serves both the partition and the insertion pass.
  always_comb begin
    if (state_r == S_ICMP) begin
      cmp_a = pivot_r;
      cmp_b = rdata_r;
    end else begin
      cmp_a = rdata_r;
      cmp_b = pivot_r;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    sp_nxt    = sp_r;
    j_nxt     = j_r;
    ip_nxt    = ip_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    pivot_nxt = pivot_r;
    tmp_nxt   = tmp_r;
    ov_nxt    = 1'b0;
    ol_nxt    = 1'b0;
    m_re = 1'b0; m_raddr = IW'(j_r);
    m_we = 1'b0; m_waddr = IW'(ip_r); m_wdata = tmp_r;
    s_re = 1'b0; s_raddr = IW'(sp_r - CW'(1));
    s_we = 1'b0; s_waddr = IW'(sp_r); s_wdata = srd_r;
    fill_add = fill_r + CW'(fill_r < CW'(DEPTH));
    unique case (state_r)
      S_IDLE: begin
        if (load) begin
          if (fill_r < CW'(DEPTH)) begin
            m_we    = 1'b1;
            m_waddr = IW'(fill_r);
            m_wdata = item.value;
          end
          fill_nxt = fill_add;
          if (item.last) begin
            j_nxt = '0;
            if (fill_add > CW'(1)) begin
              s_we      = 1'b1;
              s_waddr   = '0;
              s_wdata   = {IW'(0), IW'(fill_add - CW'(1))};
              sp_nxt    = CW'(1);
              state_nxt = S_POP;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          j_nxt     = CW'(1);
          state_nxt = S_IRD;
        end else begin
          s_re      = 1'b1;
          sp_nxt    = sp_r - CW'(1);
          state_nxt = S_PENT;
        end
      end
      S_PENT: begin
        lo_nxt = srd_r[2*IW-1:IW];
        hi_nxt = srd_r[IW-1:0];
        if (srd_r[2*IW-1:IW] >= srd_r[IW-1:0] || CW'(srd_r[IW-1:0]) >= fill_r) begin
          state_nxt = S_POP;
        end else begin
          m_re      = 1'b1;
          m_raddr   = srd_r[IW-1:0];
          j_nxt     = CW'(srd_r[2*IW-1:IW]);
          ip_nxt    = CW'(srd_r[2*IW-1:IW]);
          state_nxt = S_PPIV;
        end
      end
      S_PPIV: begin
        pivot_nxt = rdata_r;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        m_re = 1'b1;
        if (j_r < CW'(hi_r)) begin
          state_nxt = S_PCMP;
        end else begin
          m_raddr   = IW'(ip_r);
          state_nxt = S_FS1;
        end
      end
      S_PCMP: begin
        if (cmp_lt) begin
          tmp_nxt   = rdata_r;
          m_re      = 1'b1;
          m_raddr   = IW'(ip_r);
          state_nxt = S_PSW1;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_PRD;
        end
      end
      S_PSW1: begin
        m_we      = 1'b1;
        tmp_nxt   = rdata_r;
        state_nxt = S_PSW2;
      end
      S_PSW2: begin
        m_we      = 1'b1;
        m_waddr   = IW'(j_r);
        ip_nxt    = ip_r + CW'(1);
        j_nxt     = j_r + CW'(1);
        state_nxt = S_PRD;
      end
      S_FS1: begin
        m_we      = 1'b1;
        m_wdata   = pivot_r;
        tmp_nxt   = rdata_r;
        state_nxt = S_FS2;
      end
      S_FS2: begin
        m_we      = 1'b1;
        m_waddr   = hi_r;
        state_nxt = S_PUSHL;
      end
      S_PUSHL: begin
        if (CMPW'(ip_r) > CMPW'(lo_r) + CMPW'(cutoff) + CMPW'(1) && sp_r < CW'(DEPTH)) begin
          s_we    = 1'b1;
          s_wdata = {lo_r, IW'(ip_r - CW'(1))};
          sp_nxt  = sp_r + CW'(1);
        end
        state_nxt = S_PUSHR;
      end
      S_PUSHR: begin
        if (CMPW'(hi_r) > CMPW'(ip_r) + CMPW'(cutoff) && sp_r < CW'(DEPTH)) begin
          s_we    = 1'b1;
          s_wdata = {IW'(ip_r + CW'(1)), hi_r};
          sp_nxt  = sp_r + CW'(1);
        end
        state_nxt = S_POP;
      end
      S_IRD: begin
        if (j_r < fill_r) begin
          m_re      = 1'b1;
          state_nxt = S_IKEY;
        end else begin
          j_nxt     = '0;
          state_nxt = S_OUT;
        end
      end
      S_IKEY: begin
        pivot_nxt = rdata_r;
        ip_nxt    = j_r;
        state_nxt = S_IRDJ;
      end
      S_IRDJ: begin
        if (ip_r == '0) begin
          m_we      = 1'b1;
          m_wdata   = pivot_r;
          j_nxt     = j_r + CW'(1);
          state_nxt = S_IRD;
        end else begin
          m_re      = 1'b1;
          m_raddr   = IW'(ip_r - CW'(1));
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        m_we = 1'b1;
        if (cmp_lt) begin
          m_wdata   = rdata_r;
          ip_nxt    = ip_r - CW'(1);
          state_nxt = S_IRDJ;
        end else begin
          m_wdata   = pivot_r;
          j_nxt     = j_r + CW'(1);
          state_nxt = S_IRD;
        end
      end
      S_OUT: begin
        m_re   = 1'b1;
        ov_nxt = 1'b1;
        ol_nxt = (j_r == fill_r - CW'(1));
        j_nxt  = j_r + CW'(1);
        if (j_r == fill_r - CW'(1)) begin
          fill_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (m_we) mem[m_waddr] <= m_wdata;
    if (m_re) rdata_r <= mem[m_raddr];
    if (s_we) stk[s_waddr] <= s_wdata;
    if (s_re) srd_r <= stk[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      sp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      sp_r    <= sp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    ip_r    <= ip_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    pivot_r <= pivot_nxt;
    tmp_r   <= tmp_nxt;
    ol_r    <= ol_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = ov_r;
  assign res_value = rdata_r;
  assign res_last  = ol_r;

endmodule

// ===== design/quicksort_cutoff_insertion_sorter.sv =====
// Top level of the batch sorter: cutoff register, output register, sort core.
// Depends on qcis_pkg and qcis_core.
//
// Usage: present one item on in_item with start high while busy is low; the
// item is taken at that clock edge. Items are loaded one per cycle into an
// element store of DEPTH entries; items that arrive once the store is full
// are dropped. An item with last set closes the batch and raises busy.
// The batch is then sorted by a Lomuto quicksort that keeps pending ranges on
// a stack in memory, followed by an insertion sort pass. Every step uses one
// shared signed comparator and a store with one read and one write port.
// The sorted batch leaves in ascending order, one item per cycle on out_item
// with out_strobe high, the last one flagged by last_out. Results pass
// through the read and output registers. Results cannot be held off by
// the receiver, so none are buffered. busy falls as the final read is issued,
// and the next batch may start while the final two results are still in flight.
// The cutoff register (cfg_we, cfg_wdata, reset value 8) only changes how far
// quicksort descends, never the result. Reset empties the store and the stack.
module quicksort_cutoff_insertion_sorter #(
  parameter int DEPTH = qcis_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  qcis_pkg::in_item_t          in_item,
  output logic                        out_strobe,
  output qcis_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [qcis_pkg::CUT_W-1:0]  cfg_wdata
);
  import qcis_pkg::*;

  logic [CUT_W-1:0] cutoff_r;
  logic             strobe_r;
  out_item_t        item_r;
  logic             res_valid, res_last;
  logic signed [DATA_W-1:0] res_value;

  // The user must write the cutoff only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUT_RST;
      strobe_r <= 1'b0;
    end else begin
      if (cfg_we) cutoff_r <= cfg_wdata;
      strobe_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r.sorted_value <= res_value;
    item_r.last_out     <= res_last;
  end

  qcis_core #(.DEPTH(DEPTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (start && !busy),
    .item      (in_item),
    .cutoff    (cutoff_r),
    .busy      (busy),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_last  (res_last)
  );

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// ===== design/qcis_checker.sv =====
// Port-level checker of the batch sorter, attached to the top level by bind.
// Depends on qcis_pkg and the assertion macro header.
`include "quicksort_cutoff_insertion_sorter_assert.svh"

module qcis_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input qcis_pkg::in_item_t   in_item,
  input logic                 out_strobe,
  input qcis_pkg::out_item_t  out_item
);
  import qcis_pkg::*;

  // A closing item always starts a sort.
  `QCIS_ASSERT_NEXT(a_last_busy, start && !busy && in_item.last, busy, "no sort after last item")
  // An item that does not close the batch leaves the block ready.
  `QCIS_ASSERT_NEXT(a_load_ready, start && !busy && !in_item.last, !busy, "busy after plain item")
  // Nothing follows the flagged final result.
  `QCIS_ASSERT_NEXT(a_last_end, out_strobe && out_item.last_out, !out_strobe, "result after last")
  // Results only come out of a finished sort, never while loading starts.
  `QCIS_ASSERT_NOW(a_out_idle, out_strobe && !$past(out_strobe), $past(busy, 2), "stray result")

endmodule

bind quicksort_cutoff_insertion_sorter qcis_checker u_qcis_checker (.*);
